>>> hdl/qfa_pkg.sv
// ----------------------------------------------------------------------------
// qfa_pkg
// Types, constants and step functions shared by the quaternion builder.
// ----------------------------------------------------------------------------
package qfa_pkg;

   localparam int ROOT_STEPS   = 32;   // one root bit per cell, 64-bit radicand
   localparam int QUO_BITS     = 16;   // quotient bits of the axis scaling
   localparam int ATAN_ENTRIES = 30;

   localparam logic signed [31:0] GAIN_INV_Q28 = 32'sd163008219;
   localparam logic signed [31:0] PI_Q28       = 32'sd843314857;
   localparam logic signed [31:0] HALF_PI_Q28  = 32'sd421657428;
   localparam logic signed [15:0] ONE_Q12      = 16'sd4096;

   localparam logic [31:0] ATAN_Q28 [ATAN_ENTRIES] = '{
      32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
      32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
      32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
      32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
      32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
   };

   typedef enum logic [1:0] {
      SPEC_NONE     = 2'd0,
      SPEC_OPPOSITE = 2'd1,
      SPEC_ALIGNED  = 2'd2
   } spec_type;

   typedef struct packed {
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [15:0] low;
      logic [15:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                kind;
      spec_type            spec;
      logic [2:0][16:0]    ax;
      logic                neg;
      logic signed [31:0]  cx;
      logic signed [31:0]  cy;
      logic signed [31:0]  cz;
      sqrt_state_type      sq_len;
      sqrt_state_type      sq_c;
      sqrt_state_type      sq_s;
   } root_pipe_type;

   typedef struct packed {
      div_lane_type [2:0]  lane;
      logic [31:0]         den;
      logic [2:0]          sgn;
      spec_type            spec;
      logic                zero;
      logic signed [31:0]  cos28;
   } div_pipe_type;

   function automatic logic signed [31:0] atan_at(input int i);
      logic signed [31:0] r;
      r = '0;
      if (i >= 0 && i < ATAN_ENTRIES) begin
         r = $signed(ATAN_Q28[5'(i)]);
      end
      return r;
   endfunction

   function automatic logic [16:0] mag17(input logic signed [16:0] v);
      return v[16] ? 17'(-v) : 17'(v);
   endfunction

   // One digit of the restoring square root: two radicand bits in, one root bit out.
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s);
      logic [35:0]    rt;
      logic [35:0]    tr;
      sqrt_state_type r;
      rt    = {s.rem, s.rad[63:62]};
      tr    = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[61:0], 2'b00};
      if (rt >= tr) begin
         r.rem  = 34'(rt - tr);
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = rt[33:0];
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   // One bit of restoring division; the remainder always stays below den.
   function automatic div_lane_type div_step(input div_lane_type l, input logic [31:0] den);
      logic [32:0]  rt;
      div_lane_type r;
      rt    = {l.rem, l.low[15]};
      r.low = {l.low[14:0], 1'b0};
      if (rt >= {1'b0, den}) begin
         r.rem = 32'(rt - {1'b0, den});
         r.quo = {l.quo[14:0], 1'b1};
      end else begin
         r.rem = rt[31:0];
         r.quo = {l.quo[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> hdl/qfa_req_if.sv
// ----------------------------------------------------------------------------
// qfa_req_if
// Input channel of the quaternion builder: one vector item per handshake.
// ----------------------------------------------------------------------------
interface qfa_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] vec_x;
   logic signed [15:0] vec_y;
   logic signed [15:0] vec_z;
   logic signed [15:0] turn_angle;

   modport source (output valid, kind, vec_x, vec_y, vec_z, turn_angle, input ready);
   modport sink   (input valid, kind, vec_x, vec_y, vec_z, turn_angle, output ready);
endinterface

>>> hdl/qfa_rsp_if.sv
// ----------------------------------------------------------------------------
// qfa_rsp_if
// Result channel of the quaternion builder: one quaternion item per handshake.
// ----------------------------------------------------------------------------
interface qfa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] qx;
   logic signed [15:0] qy;
   logic signed [15:0] qz;
   logic signed [15:0] qw;

   modport source (output valid, qx, qy, qz, qw, input ready);
   modport sink   (input valid, qx, qy, qz, qw, output ready);
endinterface

>>> hdl/qfa_root_cell.sv
// ----------------------------------------------------------------------------
// qfa_root_cell
// One cell of the rotation chain: a CORDIC step (only in cells below CORDIC_STEPS) and three square root digits.
// ----------------------------------------------------------------------------
module qfa_root_cell #(
   parameter int INDEX        = 0,
   parameter int CORDIC_STEPS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  qfa_pkg::root_pipe_type up_data,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output qfa_pkg::root_pipe_type dn_data
);

   logic                   valid_ff;
   qfa_pkg::root_pipe_type data_ff;
   qfa_pkg::root_pipe_type data_in;
   logic signed [31:0]     dx;
   logic signed [31:0]     dy;
   logic signed [31:0]     ang;

   assign dx  = $signed(up_data.cy) >>> INDEX;
   assign dy  = $signed(up_data.cx) >>> INDEX;
   assign ang = qfa_pkg::atan_at(INDEX);

   always_comb begin
      data_in        = up_data;
      data_in.sq_len = qfa_pkg::sqrt_step(up_data.sq_len);
      data_in.sq_c   = qfa_pkg::sqrt_step(up_data.sq_c);
      data_in.sq_s   = qfa_pkg::sqrt_step(up_data.sq_s);
      if (INDEX < CORDIC_STEPS) begin
         if (!up_data.cz[31]) begin
            data_in.cx = up_data.cx - dx;
            data_in.cy = up_data.cy + dy;
            data_in.cz = up_data.cz - ang;
         end else begin
            data_in.cx = up_data.cx + dx;
            data_in.cy = up_data.cy - dy;
            data_in.cz = up_data.cz + ang;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/qfa_div_cell.sv
// ----------------------------------------------------------------------------
// qfa_div_cell
// One cell of the scaling chain: a quotient bit for each of the three lanes.
// ----------------------------------------------------------------------------
module qfa_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  qfa_pkg::div_pipe_type up_data,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output qfa_pkg::div_pipe_type dn_data
);

   logic                  valid_ff;
   qfa_pkg::div_pipe_type data_ff;
   qfa_pkg::div_pipe_type data_in;

   always_comb begin
      data_in = up_data;
      for (int i = 0; i < 3; i++) begin
         data_in.lane[i] = qfa_pkg::div_step(up_data.lane[i], up_data.den);
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/quaternion_from_axis_angle_unit.sv
// ----------------------------------------------------------------------------
// quaternion_from_axis_angle_unit
// Builds a unit quaternion (Q1.14) from an axis and angle or from a direction
// (Q3.12). The unit accepts one item in every cycle unless the result
// side stalls, and presents each result on the result channel. The item passes 52
// registers: one input stage, a chain of 32 cells that run the CORDIC for the
// half angle alongside three bit-per-cell square roots (the 64-bit axis length
// sets the chain length), a multiply stage, a rounding stage, a chain of 16
// division cells, one quotient bit each, and the output register. Every stage
// holds its item while the one after it is full, so a stall on the result
// side only backs up as far as it needs to.
// near_one_margin (reset 1) is written through csr_wr_en and csr_wr_data.
// ----------------------------------------------------------------------------
module quaternion_from_axis_angle_unit #(
   parameter int COMPONENT_BITS = 16,
   parameter int CORDIC_STEPS   = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [9:0] csr_wr_data,
   qfa_req_if.sink    req_ch,
   qfa_rsp_if.source  rsp_ch
);

   localparam int     RS = qfa_pkg::ROOT_STEPS;
   localparam int     QB = qfa_pkg::QUO_BITS;
   localparam longint CHI = (64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1;
   localparam longint SAT_HI_L = (CHI < 64'sd16384) ? CHI : 64'sd16384;
   localparam longint SAT_LO_L = ((-CHI - 64'sd1) > -64'sd16384) ? (-CHI - 64'sd1)
                                                                 : -64'sd16384;
   localparam logic signed [19:0] SAT_HI = 20'(SAT_HI_L);
   localparam logic signed [19:0] SAT_LO = 20'(SAT_LO_L);

   typedef struct packed {
      logic               kind;
      qfa_pkg::spec_type  spec;
      logic [2:0][16:0]   ax;
      logic [2:0][30:0]   sq;
      logic [13:0]        a_c;
      logic [13:0]        a_s;
      logic               neg;
      logic signed [31:0] z;
   } front_type;

   typedef struct packed {
      logic [2:0][47:0]   prod;
      logic [2:0]         sgn;
      logic [31:0]        den;
      qfa_pkg::spec_type  spec;
      logic               zero;
      logic signed [31:0] cos28;
   } mul_type;

   typedef struct packed {
      logic [15:0] qx;
      logic [15:0] qy;
      logic [15:0] qz;
      logic [15:0] qw;
   } out_type;

   function automatic logic [15:0] pack20(input logic signed [19:0] v);
      logic signed [19:0] r;
      r = v;
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return r[15:0];
   endfunction

   // Configuration
   logic [9:0] margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= 10'd1;
      end else if (csr_wr_en) begin
         margin_ff <= csr_wr_data;
      end
   end

   // Input stage
   logic               front_vld_ff;
   logic               front_ready;
   front_type          front_ff;
   front_type          front_in;
   logic signed [16:0] d_opp;
   logic signed [16:0] d_aln;
   logic signed [15:0] c_clamp;
   logic signed [31:0] z_raw;
   logic [16:0]        am_f [3];
   logic [31:0]        sq_full [3];

   always_comb begin
      d_opp = $signed({req_ch.vec_z[15], req_ch.vec_z}) + 17'sd4096;
      d_aln = $signed({req_ch.vec_z[15], req_ch.vec_z}) - 17'sd4096;

      front_in.kind = req_ch.kind;
      front_in.spec = qfa_pkg::SPEC_NONE;
      if (req_ch.kind) begin
         // The opposite test wins when both would hold.
         if (qfa_pkg::mag17(d_opp) < {7'd0, margin_ff}) begin
            front_in.spec = qfa_pkg::SPEC_OPPOSITE;
         end else if (qfa_pkg::mag17(d_aln) < {7'd0, margin_ff}) begin
            front_in.spec = qfa_pkg::SPEC_ALIGNED;
         end
      end

      if (req_ch.kind) begin
         front_in.ax[0] = 17'(-$signed({req_ch.vec_y[15], req_ch.vec_y}));
         front_in.ax[1] = {req_ch.vec_x[15], req_ch.vec_x};
         front_in.ax[2] = '0;
      end else begin
         front_in.ax[0] = {req_ch.vec_x[15], req_ch.vec_x};
         front_in.ax[1] = {req_ch.vec_y[15], req_ch.vec_y};
         front_in.ax[2] = {req_ch.vec_z[15], req_ch.vec_z};
      end
      for (int i = 0; i < 3; i++) begin
         am_f[i]           = qfa_pkg::mag17(front_in.ax[i]);
         sq_full[i]        = am_f[i][15:0] * am_f[i][15:0];
         front_in.sq[i]    = sq_full[i][30:0];
      end

      if (req_ch.vec_z > qfa_pkg::ONE_Q12) begin
         c_clamp = qfa_pkg::ONE_Q12;
      end else if (req_ch.vec_z < -qfa_pkg::ONE_Q12) begin
         c_clamp = -qfa_pkg::ONE_Q12;
      end else begin
         c_clamp = req_ch.vec_z;
      end
      front_in.a_c = 14'(qfa_pkg::ONE_Q12 + c_clamp);
      front_in.a_s = 14'(qfa_pkg::ONE_Q12 - c_clamp);

      // Half angle in Q.28, folded into [-pi/2, pi/2] with a sign flip.
      z_raw        = $signed({req_ch.turn_angle[15], req_ch.turn_angle, 15'd0});
      front_in.neg = 1'b0;
      front_in.z   = z_raw;
      if (z_raw > qfa_pkg::HALF_PI_Q28) begin
         front_in.z   = z_raw - qfa_pkg::PI_Q28;
         front_in.neg = 1'b1;
      end else if (z_raw < -qfa_pkg::HALF_PI_Q28) begin
         front_in.z   = z_raw + qfa_pkg::PI_Q28;
         front_in.neg = 1'b1;
      end
   end

   // Rotation and root chain
   logic                   chain_valid [RS+1];
   logic                   chain_ready [RS+1];
   qfa_pkg::root_pipe_type chain_data  [RS+1];
   logic [31:0]            sq_sum;

   assign front_ready  = !front_vld_ff || chain_ready[0];
   assign req_ch.ready = front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else if (front_ready) begin
         front_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready) begin
         front_ff <= front_in;
      end
   end

   always_comb begin
      sq_sum = {1'b0, front_ff.sq[0]} + {1'b0, front_ff.sq[1]} + {1'b0, front_ff.sq[2]};
      chain_data[0].kind        = front_ff.kind;
      chain_data[0].spec        = front_ff.spec;
      chain_data[0].ax          = front_ff.ax;
      chain_data[0].neg         = front_ff.neg;
      chain_data[0].cx          = qfa_pkg::GAIN_INV_Q28;
      chain_data[0].cy          = '0;
      chain_data[0].cz          = front_ff.z;
      chain_data[0].sq_len.rad  = {sq_sum, 32'd0};
      chain_data[0].sq_len.rem  = '0;
      chain_data[0].sq_len.root = '0;
      chain_data[0].sq_c.rad    = {7'd0, front_ff.a_c, 43'd0};
      chain_data[0].sq_c.rem    = '0;
      chain_data[0].sq_c.root   = '0;
      chain_data[0].sq_s.rad    = {7'd0, front_ff.a_s, 43'd0};
      chain_data[0].sq_s.rem    = '0;
      chain_data[0].sq_s.root   = '0;
   end
   assign chain_valid[0] = front_vld_ff;

   for (genvar g = 0; g < RS; g++) begin : g_root
      qfa_root_cell #(
         .INDEX        (g),
         .CORDIC_STEPS (CORDIC_STEPS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[g]),
         .up_ready (chain_ready[g]),
         .up_data  (chain_data[g]),
         .dn_valid (chain_valid[g+1]),
         .dn_ready (chain_ready[g+1]),
         .dn_data  (chain_data[g+1])
      );
   end

   // Multiply stage: sine times axis, sign and magnitude apart
   logic                   mul_vld_ff;
   logic                   mul_ready;
   mul_type                mul_ff;
   mul_type                mul_in;
   qfa_pkg::root_pipe_type last;
   logic signed [31:0]     sin28;
   logic [31:0]            smag;
   logic [16:0]            am_m [3];

   assign last = chain_data[RS];

   always_comb begin
      if (last.kind) begin
         sin28        = $signed(last.sq_s.root);
         mul_in.cos28 = $signed(last.sq_c.root);
      end else begin
         sin28        = last.neg ? -last.cy : last.cy;
         mul_in.cos28 = last.neg ? -last.cx : last.cx;
      end
      smag = sin28[31] ? 32'(-sin28) : 32'(sin28);
      for (int i = 0; i < 3; i++) begin
         am_m[i]        = qfa_pkg::mag17(last.ax[i]);
         mul_in.prod[i] = {46'(smag[29:0]) * 46'(am_m[i][15:0]), 2'b00};
         mul_in.sgn[i]  = sin28[31] ^ last.ax[i][16];
      end
      mul_in.den  = last.sq_len.root;
      mul_in.zero = (last.sq_len.root == '0);
      mul_in.spec = last.spec;
   end

   // Rounding stage feeds the division chain.
   logic                  rnd_vld_ff;
   logic                  rnd_ready;
   qfa_pkg::div_pipe_type rnd_ff;
   qfa_pkg::div_pipe_type rnd_in;
   logic [47:0]           num [3];
   logic                  div_valid [QB+1];
   logic                  div_ready [QB+1];
   qfa_pkg::div_pipe_type div_data  [QB+1];

   assign mul_ready       = !mul_vld_ff || rnd_ready;
   assign chain_ready[RS] = mul_ready;
   assign rnd_ready       = !rnd_vld_ff || div_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         rnd_vld_ff <= 1'b0;
      end else begin
         if (mul_ready) mul_vld_ff <= chain_valid[RS];
         if (rnd_ready) rnd_vld_ff <= mul_vld_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i]             = mul_ff.prod[i] + {17'd0, mul_ff.den[31:1]};
         rnd_in.lane[i].rem = num[i][47:16];
         rnd_in.lane[i].low = num[i][15:0];
         rnd_in.lane[i].quo = '0;
      end
      rnd_in.den   = mul_ff.den;
      rnd_in.sgn   = mul_ff.sgn;
      rnd_in.spec  = mul_ff.spec;
      rnd_in.zero  = mul_ff.zero;
      rnd_in.cos28 = mul_ff.cos28;
   end

   always_ff @(posedge clock) begin
      if (mul_ready) mul_ff <= mul_in;
      if (rnd_ready) rnd_ff <= rnd_in;
   end

   assign div_valid[0] = rnd_vld_ff;
   assign div_data[0]  = rnd_ff;

   for (genvar g = 0; g < QB; g++) begin : g_div
      qfa_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[g]),
         .up_ready (div_ready[g]),
         .up_data  (div_data[g]),
         .dn_valid (div_valid[g+1]),
         .dn_ready (div_ready[g+1]),
         .dn_data  (div_data[g+1])
      );
   end

   // Output register
   logic                  out_vld_ff;
   logic                  out_ready;
   out_type               out_ff;
   out_type               out_in;
   qfa_pkg::div_pipe_type fin;
   logic signed [19:0]    v [3];
   logic signed [32:0]    w_sum;
   logic signed [32:0]    w_shift;
   logic signed [19:0]    w_val;

   assign fin = div_data[QB];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (fin.zero) begin
            v[i] = '0;
         end else if (fin.sgn[i]) begin
            v[i] = -$signed({4'd0, fin.lane[i].quo});
         end else begin
            v[i] = $signed({4'd0, fin.lane[i].quo});
         end
      end
      w_sum   = $signed({fin.cos28[31], fin.cos28}) + 33'sd8192;
      w_shift = w_sum >>> 14;
      w_val   = w_shift[19:0];
      case (fin.spec)
         qfa_pkg::SPEC_OPPOSITE: begin
            out_in.qx = pack20(20'sd0);
            out_in.qy = pack20(20'sd16384);
            out_in.qz = pack20(20'sd0);
            out_in.qw = pack20(20'sd0);
         end
         qfa_pkg::SPEC_ALIGNED: begin
            out_in.qx = pack20(20'sd0);
            out_in.qy = pack20(20'sd0);
            out_in.qz = pack20(20'sd0);
            out_in.qw = pack20(20'sd16384);
         end
         default: begin
            out_in.qx = pack20(v[0]);
            out_in.qy = pack20(v[1]);
            out_in.qz = pack20(v[2]);
            out_in.qw = pack20(w_val);
         end
      endcase
   end

   assign out_ready     = !out_vld_ff || rsp_ch.ready;
   assign div_ready[QB] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ready) begin
         out_vld_ff <= div_valid[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.qx    = $signed(out_ff.qx);
   assign rsp_ch.qy    = $signed(out_ff.qy);
   assign rsp_ch.qz    = $signed(out_ff.qz);
   assign rsp_ch.qw    = $signed(out_ff.qw);

endmodule

>>> bench/tb_quaternion_from_axis_angle_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_from_axis_angle_unit
// Drives axis-angle and direction items with random gaps on both channels.
// Each result is checked against a quaternion predicted in the bench.
// ----------------------------------------------------------------------------
module tb_quaternion_from_axis_angle_unit;

   localparam int  LATENCY   = 52;
   localparam int  N_RANDOM  = 900;
   localparam int  N_PHASES  = 5;
   localparam int  CORDIC_STEPS = 14;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] vec_x;
      logic signed [15:0] vec_y;
      logic signed [15:0] vec_z;
      logic signed [15:0] turn_angle;
   } vec_item_type;

   typedef struct packed {
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
   } quat_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [9:0] csr_wr_data;

   qfa_req_if req_ch ();
   qfa_rsp_if rsp_ch ();

   quaternion_from_axis_angle_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   vec_item_type pending_items[$];
   quat_type     expected_quats[$];
   logic [9:0] margin;
   int        mismatches;
   longint    cycles;
   int        send_gap;
   int        recv_gap;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] clip(longint v);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return 16'(v);
   endfunction

   function automatic longint scale_round(longint num, longint unsigned den);
      longint unsigned m, q;
      m = (num < 0) ? longint'(-num) : longint'(num);
      q = (m + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic quat_type predict_quat(vec_item_type it, logic [9:0] eps);
      quat_type q;
      longint ax[3];
      longint s28, c28, x, y, z, dx, dy, c, vz;
      longint unsigned sum, len;
      logic flip;
      vz = it.vec_z;
      if (it.kind == 1'b0) begin
         ax[0] = it.vec_x;
         ax[1] = it.vec_y;
         ax[2] = it.vec_z;
         z = longint'(it.turn_angle) * 32768;
         x = qfa_pkg::GAIN_INV_Q28;
         y = 0;
         flip = 1'b0;
         if (z > qfa_pkg::HALF_PI_Q28) begin
            z -= qfa_pkg::PI_Q28;
            flip = 1'b1;
         end else if (z < -qfa_pkg::HALF_PI_Q28) begin
            z += qfa_pkg::PI_Q28;
            flip = 1'b1;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(qfa_pkg::ATAN_Q28[i]);
            end else begin
               x += dx; y -= dy; z += longint'(qfa_pkg::ATAN_Q28[i]);
            end
         end
         s28 = flip ? -y : y;
         c28 = flip ? -x : x;
      end else begin
         // The opposite test wins when both would match.
         if ((vz + 4096 < 0 ? -(vz + 4096) : vz + 4096) < eps) begin
            q = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
            return q;
         end
         if ((vz - 4096 < 0 ? -(vz - 4096) : vz - 4096) < eps) begin
            q = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
            return q;
         end
         c = vz;
         if (c > 4096) c = 4096;
         if (c < -4096) c = -4096;
         c28 = longint'(root64(longint'(4096 + c) << 43));
         s28 = longint'(root64(longint'(4096 - c) << 43));
         ax[0] = -longint'(it.vec_y);
         ax[1] = it.vec_x;
         ax[2] = 0;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += longint'(ax[i] * ax[i]);
      if (sum == 0) begin
         q.qx = 0; q.qy = 0; q.qz = 0;
      end else begin
         len = root64(sum << 32);
         q.qx = clip(scale_round(s28 * ax[0] * 4, len));
         q.qy = clip(scale_round(s28 * ax[1] * 4, len));
         q.qz = clip(scale_round(s28 * ax[2] * 4, len));
      end
      q.qw = clip(shr_floor(c28 + 8192, 14));
      return q;
   endfunction

   function automatic logic signed [15:0] rnd16();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'sd4096 - 16'($urandom_range(0, 40));
         2: return -16'sd4096 + 16'($urandom_range(0, 40));
         3: return 16'($urandom_range(0, 8)) - 16'sd4;
         default: return 16'($urandom_range(0, 16384)) - 16'sd8192;
      endcase
   endfunction

   task automatic queue_item(logic k, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic signed [15:0] a);
      vec_item_type it;
      it.kind = k; it.vec_x = x; it.vec_y = y; it.vec_z = z; it.turn_angle = a;
      pending_items.push_back(it);
   endtask

   task automatic write_margin(logic [9:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Wait until every queued item was sent and every result came back.
   task automatic drain();
      while (pending_items.size() != 0 || expected_quats.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_quats.push_back(predict_quat({req_ch.kind, req_ch.vec_x,
               req_ch.vec_y, req_ch.vec_z, req_ch.turn_angle}, margin));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0 || pending_items.size() == 0) begin
               req_ch.valid <= 1'b0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               vec_item_type it;
               it = pending_items.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.kind       <= it.kind;
               req_ch.vec_x      <= it.vec_x;
               req_ch.vec_y      <= it.vec_y;
               req_ch.vec_z      <= it.vec_z;
               req_ch.turn_angle <= it.turn_angle;
               send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            quat_type want;
            if (expected_quats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result %p", rsp_ch.qx);
            end else begin
               want = expected_quats.pop_front();
               if (rsp_ch.qx !== want.qx || rsp_ch.qy !== want.qy ||
                   rsp_ch.qz !== want.qz || rsp_ch.qw !== want.qw) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected (%0d %0d %0d %0d) got (%0d %0d %0d %0d)",
                        want.qx, want.qy, want.qz, want.qw,
                        rsp_ch.qx, rsp_ch.qy, rsp_ch.qz, rsp_ch.qw);
               end
            end
         end
         if (recv_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_ch.valid && rsp_ch.ready && $urandom_range(0, 2) != 0)
               recv_gap <= $urandom_range(0, 14);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [9:0] phase_margin [N_PHASES];
      logic [9:0] mv;
      phase_margin = '{10'd1, 10'd0, 10'd1023, 10'd37, 10'd5};
      mismatches   = 0;
      cycles       = 0;
      margin       = 10'd1;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_ch.valid = 1'b0;
      req_ch.kind  = 1'b0;
      req_ch.vec_x = '0;
      req_ch.vec_y = '0;
      req_ch.vec_z = '0;
      req_ch.turn_angle = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, zero axis, aligned and opposite directions.
      queue_item(0, 16'sd4096, 0, 0, 16'sd6434);
      queue_item(0, 0, 0, 0, 16'sd1000);
      queue_item(0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
      queue_item(0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      queue_item(0, 0, 0, 16'sd1, 16'sd12868);
      queue_item(0, 16'sd1, 16'sd1, 16'sd1, -16'sd12868);
      queue_item(0, -16'sd1, 0, 0, 0);
      queue_item(1, 0, 0, 16'sd4096, 0);
      queue_item(1, 0, 0, -16'sd4096, 0);
      queue_item(1, 16'sd100, 0, -16'sd4095, 0);
      queue_item(1, 16'sd100, 0, 16'sd4095, 0);
      queue_item(1, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
      queue_item(1, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
      queue_item(1, 0, 0, 0, 0);
      queue_item(1, 16'sd2896, 16'sd2896, 0, 0);
      drain();

      for (int p = 0; p < N_PHASES; p++) begin
         mv = phase_margin[p];
         write_margin(mv);
         margin = mv;
         for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
            if (n % 40 == 0) begin
               // Direction items right at the margin edges.
               queue_item(1, rnd16(), rnd16(), 16'sd4096 - 16'(mv), rnd16());
               queue_item(1, rnd16(), rnd16(), -16'sd4096 + 16'(mv) - 16'sd1, rnd16());
            end
            queue_item(1'($urandom_range(0, 1)), rnd16(), rnd16(), rnd16(),
                       16'($urandom_range(0, 65535)));
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/qfa_pkg.sv
hdl/qfa_req_if.sv
hdl/qfa_rsp_if.sv
hdl/qfa_root_cell.sv
hdl/qfa_div_cell.sv
hdl/quaternion_from_axis_angle_unit.sv
bench/tb_quaternion_from_axis_angle_unit.sv
